[src/bbc_pkg.sv]
// Shared types, codes and sizes for the block buffer cache.
// No dependencies; the interfaces and design files use it by scoped names, the testbench files import it.
package bbc_pkg;

	localparam int SLOTS   = 32;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = SLOT_W + 1;
	localparam int FSLOT_W = 5;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int REFS_W  = 8;

	typedef enum logic [1:0] {
		FN_GET      = 2'd0,
		FN_WRITE    = 2'd1,
		FN_RELEASE  = 2'd2,
		FN_COMPLETE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		DR_NONE  = 2'd0,
		DR_READ  = 2'd1,
		DR_WRITE = 2'd2
	} dreq_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_NOTHELD = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HSCAN,
		S_MSCAN,
		S_EUPD,
		S_FIND,
		S_SHIFT,
		S_FRONT,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic [DEV_W-1:0]  device;
		logic [BLK_W-1:0]  block;
		logic [REFS_W-1:0] refs;
		logic              valid;
		logic              dirty;
	} entry_t;

	// Entry memory access group (one read, one write per cycle)
	typedef struct packed {
		logic [SLOT_W-1:0] ra;
		logic              we;
		logic [SLOT_W-1:0] wa;
		entry_t            wd;
	} ent_port_t;

	// Recency order memory access group: position -> slot
	typedef struct packed {
		logic [SLOT_W-1:0] ra;
		logic              we;
		logic [SLOT_W-1:0] wa;
		logic [SLOT_W-1:0] wd;
	} ord_port_t;

	// Slot index to the 5-bit result field (masked / zero-extended)
	function automatic logic [FSLOT_W-1:0] to_field(input logic [SLOT_W-1:0] e);
		logic [FSLOT_W+SLOT_W-1:0] t;
		t = {{FSLOT_W{1'b0}}, e};
		return t[FSLOT_W-1:0];
	endfunction

	// 5-bit slot field to an index
	function automatic logic [SLOT_W-1:0] to_index(input logic [FSLOT_W-1:0] s);
		logic [FSLOT_W+SLOT_W-1:0] t;
		t = {{SLOT_W{1'b0}}, s};
		return t[SLOT_W-1:0];
	endfunction

	// Slot field names an existing slot
	function automatic logic slot_ok(input logic [FSLOT_W-1:0] s);
		logic [FSLOT_W+SLOT_W-1:0] t;
		t = {{SLOT_W{1'b0}}, s};
		return t < (FSLOT_W + SLOT_W)'(SLOTS);
	endfunction

endpackage

[src/bbc_req_if.sv]
// Request channel: valid/ready handshake carrying one cache operation.
// Depends on bbc_pkg for field widths.
interface bbc_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  func;
	logic [bbc_pkg::DEV_W-1:0]   device;
	logic [bbc_pkg::BLK_W-1:0]   block_number;
	logic [bbc_pkg::FSLOT_W-1:0] slot;

	modport source (output valid, func, device, block_number, slot, input ready);
	modport sink (input valid, func, device, block_number, slot, output ready);
endinterface

[src/bbc_rsp_if.sv]
// Response channel: valid/ready handshake carrying one operation result.
// Depends on bbc_pkg for field widths.
interface bbc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bbc_pkg::FSLOT_W-1:0] slot_out;
	logic                        hit;
	logic [1:0]                  disk_request;
	logic [1:0]                  status;

	modport source (output valid, slot_out, hit, disk_request, status, input ready);
	modport sink (input valid, slot_out, hit, disk_request, status, output ready);
endinterface

[src/block_buffer_cache_lru.sv]
// Block buffer cache with LRU recency order: entry and order memories plus
// the sequencer. Uses bbc_pkg, bbc_req_if, bbc_rsp_if, bbc_ram, bbc_ctrl.
//
// One operation is in flight at a time; the result sits in an output register
// so the next request is taken while it waits. The order memory is walked one
// position per cycle with one read port: a get scans for a hit, then for a free
// buffer on a miss; write, complete and a release that keeps references update
// the entry only; a release that drops to zero adds a search for the slot's
// position and a shift of the positions before it to bring it to the front.
// No clearing pass is needed after reset: per-entry written marks stand in.
module block_buffer_cache_lru (
	input  logic       clk,
	input  logic       arst_n,
	bbc_req_if.sink    req,
	bbc_rsp_if.source  rsp
);
	bbc_pkg::ent_port_t         ent_p;
	bbc_pkg::ord_port_t         ord_p;
	bbc_pkg::entry_t            ent_rd;
	logic [bbc_pkg::SLOT_W-1:0] ord_rd;

	// slot entries: device, block, refs, valid, dirty
	bbc_ram #(.W($bits(bbc_pkg::entry_t)), .D(bbc_pkg::SLOTS)) u_ent_ram (
		.clk (clk),
		.we  (ent_p.we),
		.wa  (ent_p.wa),
		.wd  (ent_p.wd),
		.ra  (ent_p.ra),
		.rd  (ent_rd)
	);

	// recency order, position zero most recent
	bbc_ram #(.W(bbc_pkg::SLOT_W), .D(bbc_pkg::SLOTS)) u_ord_ram (
		.clk (clk),
		.we  (ord_p.we),
		.wa  (ord_p.wa),
		.wd  (ord_p.wd),
		.ra  (ord_p.ra),
		.rd  (ord_rd)
	);

	bbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ent_p  (ent_p),
		.ent_rd (ent_rd),
		.ord_p  (ord_p),
		.ord_rd (ord_rd)
	);

	// entry and order updates never happen in the same cycle
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ent_p.we && ord_p.we))
		else $error("entry and order writes overlap");

	// a hit is always a successful get
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> rsp.status == bbc_pkg::ST_OK)
		else $error("hit with error status");

	// failed operations request no disk traffic
	a_err_nodisk: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != bbc_pkg::ST_OK |-> rsp.disk_request == bbc_pkg::DR_NONE)
		else $error("disk request on failed operation");

	// no request taken while an order update is in progress
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ord_p.we |-> !req.ready)
		else $error("request ready during recency update");

endmodule

[src/bbc_ram.sv]
// Generic simple dual-port RAM: one write and one registered read per cycle.
// No dependencies.
module bbc_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] wa,
	input  logic [W-1:0]         wd,
	input  logic [$clog2(D)-1:0] ra,
	output logic [W-1:0]         rd
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule

[src/bbc_ctrl.sv]
// Sequencer of the buffer cache: scans, read-modify-write of slot entries,
// recency shifting and the output register. Uses bbc_pkg and both channel
// interfaces; drives the entry and order memories held in the top level.
module bbc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	bbc_req_if.sink                     req,
	bbc_rsp_if.source                   rsp,
	output bbc_pkg::ent_port_t          ent_p,
	input  bbc_pkg::entry_t             ent_rd,
	output bbc_pkg::ord_port_t          ord_p,
	input  logic [bbc_pkg::SLOT_W-1:0]  ord_rd
);
	bbc_pkg::fsm_t state_q, state_d;

	// current item
	bbc_pkg::func_t                func_q;
	logic [bbc_pkg::DEV_W-1:0]     dev_q;
	logic [bbc_pkg::BLK_W-1:0]     blk_q;
	logic [bbc_pkg::FSLOT_W-1:0]   slot_q;
	logic [bbc_pkg::SLOT_W-1:0]    sidx_q;

	// scan pipeline: stage 1 order read, stage 2 entry read
	logic [bbc_pkg::CNT_W-1:0]     iss_q;
	logic                          v1_s1, ov_s1;
	logic [bbc_pkg::SLOT_W-1:0]    p1_s1;
	logic                          v2_s2, ev_s2;
	logic [bbc_pkg::SLOT_W-1:0]    e_s2;
	logic [bbc_pkg::SLOT_W-1:0]    sq_q;

	// per-entry written marks; unwritten entries read as reset values
	logic [bbc_pkg::SLOTS-1:0]     ent_vld_q, ord_vld_q;

	// pending result and output register
	logic [bbc_pkg::FSLOT_W-1:0]   rs_slot_q, rs_slot_d;
	logic                          rs_hit_q, rs_hit_d;
	bbc_pkg::dreq_t                rs_req_q, rs_req_d;
	bbc_pkg::status_t              rs_st_q, rs_st_d;
	logic                          rs_ld;
	logic                          o_vld_q;
	logic [bbc_pkg::FSLOT_W-1:0]   o_slot_q;
	logic                          o_hit_q;
	logic [1:0]                    o_req_q, o_st_q;

	logic                          acc, scan_issue, scan_empty, find_empty;
	logic                          hmatch, mmatch, fmatch, out_ld;
	logic [bbc_pkg::SLOT_W-1:0]    scan_pos, e1;
	bbc_pkg::entry_t               ent2;

	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == bbc_pkg::S_IDLE);

	// stage decode
	assign e1 = ov_s1 ? ord_rd : (bbc_pkg::SLOT_W'(bbc_pkg::SLOTS - 1) - p1_s1);
	assign ent2 = ev_s2 ? ent_rd : '0;
	assign scan_issue = iss_q < bbc_pkg::CNT_W'(bbc_pkg::SLOTS);
	assign scan_pos = (state_q == bbc_pkg::S_MSCAN) ?
		bbc_pkg::SLOT_W'(bbc_pkg::SLOTS - 1) - iss_q[bbc_pkg::SLOT_W-1:0] :
		iss_q[bbc_pkg::SLOT_W-1:0];
	assign scan_empty = !scan_issue && !v1_s1 && !v2_s2;
	assign find_empty = !scan_issue && !v1_s1;
	assign hmatch = v2_s2 && ent2.device == dev_q && ent2.block == blk_q;
	assign mmatch = v2_s2 && ent2.refs == '0 && !ent2.dirty;
	assign fmatch = v1_s1 && e1 == sidx_q;
	assign out_ld = (state_q == bbc_pkg::S_RESP) && (!o_vld_q || rsp.ready);

	// next state, memory accesses, result
	always_comb begin
		state_d   = state_q;
		ent_p     = '0;
		ord_p     = '0;
		rs_ld     = 1'b0;
		rs_slot_d = slot_q;
		rs_hit_d  = 1'b0;
		rs_req_d  = bbc_pkg::DR_NONE;
		rs_st_d   = bbc_pkg::ST_OK;
		ent_p.ra  = e1;
		ord_p.ra  = scan_pos;
		case (state_q)
			bbc_pkg::S_IDLE: begin
				ent_p.ra = bbc_pkg::to_index(req.slot);
				if (acc) begin
					if (bbc_pkg::func_t'(req.func) == bbc_pkg::FN_GET) begin
						state_d = bbc_pkg::S_HSCAN;
					end else if (!bbc_pkg::slot_ok(req.slot)) begin
						rs_ld     = 1'b1;
						rs_slot_d = req.slot;
						rs_st_d   = bbc_pkg::ST_NOTHELD;
						state_d   = bbc_pkg::S_RESP;
					end else begin
						state_d = bbc_pkg::S_EUPD;
					end
				end
			end
			bbc_pkg::S_HSCAN: begin
				if (hmatch) begin
					ent_p.we  = 1'b1;
					ent_p.wa  = e_s2;
					ent_p.wd  = ent2;
					if (ent2.refs != '1) begin
						ent_p.wd.refs = ent2.refs + bbc_pkg::REFS_W'(1);
					end
					rs_ld     = 1'b1;
					rs_slot_d = bbc_pkg::to_field(e_s2);
					rs_hit_d  = 1'b1;
					rs_req_d  = ent2.valid ? bbc_pkg::DR_NONE : bbc_pkg::DR_READ;
					state_d   = bbc_pkg::S_RESP;
				end else if (scan_empty) begin
					state_d = bbc_pkg::S_MSCAN;
				end
			end
			bbc_pkg::S_MSCAN: begin
				if (mmatch) begin
					ent_p.we        = 1'b1;
					ent_p.wa        = e_s2;
					ent_p.wd.device = dev_q;
					ent_p.wd.block  = blk_q;
					ent_p.wd.refs   = bbc_pkg::REFS_W'(1);
					rs_ld     = 1'b1;
					rs_slot_d = bbc_pkg::to_field(e_s2);
					rs_req_d  = bbc_pkg::DR_READ;
					state_d   = bbc_pkg::S_RESP;
				end else if (scan_empty) begin
					rs_ld     = 1'b1;
					rs_slot_d = '0;
					rs_st_d   = bbc_pkg::ST_NOFREE;
					state_d   = bbc_pkg::S_RESP;
				end
			end
			bbc_pkg::S_EUPD: begin
				rs_ld   = 1'b1;
				state_d = bbc_pkg::S_RESP;
				ent_p.wa = sidx_q;
				ent_p.wd = ent2;
				case (func_q)
					bbc_pkg::FN_WRITE: begin
						if (ent2.refs != '0) begin
							ent_p.we       = 1'b1;
							ent_p.wd.dirty = 1'b1;
							rs_req_d       = bbc_pkg::DR_WRITE;
						end else begin
							rs_st_d = bbc_pkg::ST_NOTHELD;
						end
					end
					bbc_pkg::FN_RELEASE: begin
						if (ent2.refs != '0) begin
							ent_p.we      = 1'b1;
							ent_p.wd.refs = ent2.refs - bbc_pkg::REFS_W'(1);
							if (ent2.refs == bbc_pkg::REFS_W'(1)) begin
								state_d = bbc_pkg::S_FIND;
							end
						end else begin
							rs_st_d = bbc_pkg::ST_NOTHELD;
						end
					end
					default: begin
						ent_p.we       = 1'b1;
						ent_p.wd.valid = 1'b1;
						ent_p.wd.dirty = 1'b0;
					end
				endcase
			end
			bbc_pkg::S_FIND: begin
				if (fmatch) begin
					state_d = (p1_s1 == '0) ? bbc_pkg::S_FRONT : bbc_pkg::S_SHIFT;
				end else if (find_empty) begin
					state_d = bbc_pkg::S_RESP;
				end
			end
			bbc_pkg::S_SHIFT: begin
				// read position q-1, write it into q in the next cycle
				ord_p.ra = sq_q - bbc_pkg::SLOT_W'(1);
				if (v1_s1) begin
					ord_p.we = 1'b1;
					ord_p.wa = p1_s1 + bbc_pkg::SLOT_W'(1);
					ord_p.wd = e1;
				end
				if (sq_q == '0) begin
					state_d = bbc_pkg::S_FRONT;
				end
			end
			bbc_pkg::S_FRONT: begin
				ord_p.we = 1'b1;
				ord_p.wa = '0;
				ord_p.wd = sidx_q;
				state_d  = bbc_pkg::S_RESP;
			end
			bbc_pkg::S_RESP: begin
				if (out_ld) begin
					state_d = bbc_pkg::S_IDLE;
				end
			end
			default: state_d = bbc_pkg::S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bbc_pkg::S_IDLE;
			iss_q     <= '0;
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			ent_vld_q <= '0;
			ord_vld_q <= '0;
			o_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ent_p.we) begin
				ent_vld_q[ent_p.wa] <= 1'b1;
			end
			if (ord_p.we) begin
				ord_vld_q[ord_p.wa] <= 1'b1;
			end
			if (state_d != state_q) begin
				iss_q <= '0;
				v1_s1 <= 1'b0;
				v2_s2 <= 1'b0;
			end else if (state_q inside {bbc_pkg::S_HSCAN, bbc_pkg::S_MSCAN,
					bbc_pkg::S_FIND}) begin
				iss_q <= iss_q + bbc_pkg::CNT_W'(scan_issue);
				v1_s1 <= scan_issue;
				v2_s2 <= v1_s1;
			end else if (state_q == bbc_pkg::S_SHIFT) begin
				v1_s1 <= (sq_q != '0);
			end
			if (out_ld) begin
				o_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				o_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= bbc_pkg::func_t'(req.func);
			dev_q  <= req.device;
			blk_q  <= req.block_number;
			slot_q <= req.slot;
			sidx_q <= bbc_pkg::to_index(req.slot);
			ev_s2  <= ent_vld_q[bbc_pkg::to_index(req.slot)];
		end else if (state_q == bbc_pkg::S_HSCAN || state_q == bbc_pkg::S_MSCAN) begin
			e_s2  <= e1;
			ev_s2 <= ent_vld_q[e1];
		end
		if (state_q == bbc_pkg::S_SHIFT) begin
			p1_s1 <= sq_q - bbc_pkg::SLOT_W'(1);
			ov_s1 <= ord_vld_q[sq_q - bbc_pkg::SLOT_W'(1)];
			sq_q  <= sq_q - bbc_pkg::SLOT_W'(1);
		end else begin
			p1_s1 <= scan_pos;
			ov_s1 <= ord_vld_q[scan_pos];
			if (state_q == bbc_pkg::S_FIND) begin
				sq_q <= p1_s1;
			end
		end
		if (rs_ld) begin
			rs_slot_q <= rs_slot_d;
			rs_hit_q  <= rs_hit_d;
			rs_req_q  <= rs_req_d;
			rs_st_q   <= rs_st_d;
		end
		if (out_ld) begin
			o_slot_q <= rs_slot_q;
			o_hit_q  <= rs_hit_q;
			o_req_q  <= rs_req_q;
			o_st_q   <= rs_st_q;
		end
	end

	assign rsp.valid        = o_vld_q;
	assign rsp.slot_out     = o_slot_q;
	assign rsp.hit          = o_hit_q;
	assign rsp.disk_request = o_req_q;
	assign rsp.status       = o_st_q;

endmodule

[tb/sv/block_buffer_cache_lru_check.sv]
// Checker for the block buffer cache: watches request and response transfers,
// predicts each result with its own cache model and compares. Uses bbc_pkg.
module block_buffer_cache_lru_check (
	input  logic   clk,
	input  logic   arst_n,
	bbc_req_if.sink req,
	bbc_rsp_if.sink rsp,
	output int     errors,
	output int     pending,
	output int     gets_hit,
	output int     gets_miss,
	output int     nofree_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import bbc_pkg::*;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       hit;
		dreq_t      dreq;
		status_t    status;
	} cache_result_t;

	logic [DEV_W-1:0]  m_dev [SLOTS];
	logic [BLK_W-1:0]  m_blk [SLOTS];
	logic [REFS_W-1:0] m_refs [SLOTS];
	logic              m_valid [SLOTS];
	logic              m_dirty [SLOTS];
	int                m_order [SLOTS];
	cache_result_t     expected_results [$];

	// Model of one operation on the cache
	function automatic cache_result_t cache_apply(logic [1:0] fn, logic [7:0] dev,
			logic [31:0] blk, logic [4:0] s);
		cache_result_t r;
		bit done;
		int e, p;
		r = '{slot_out: s, hit: 1'b0, dreq: DR_NONE, status: ST_OK};
		done = 0;
		case (func_t'(fn))
			FN_GET: begin
				r.slot_out = '0;
				for (int i = 0; i < SLOTS && !done; i++) begin
					e = m_order[i];
					if (m_dev[e] == dev && m_blk[e] == blk) begin
						if (m_refs[e] != 8'd255) m_refs[e]++;
						r.slot_out = 5'(e);
						r.hit = 1'b1;
						r.dreq = m_valid[e] ? DR_NONE : DR_READ;
						done = 1;
						gets_hit++;
					end
				end
				for (int i = SLOTS - 1; i >= 0 && !done; i--) begin
					e = m_order[i];
					if (m_refs[e] == 0 && !m_dirty[e]) begin
						m_refs[e] = 1;
						m_dev[e] = dev;
						m_blk[e] = blk;
						m_valid[e] = 0;
						m_dirty[e] = 0;
						r.slot_out = 5'(e);
						r.dreq = DR_READ;
						done = 1;
						gets_miss++;
					end
				end
				if (!done) begin
					r.status = ST_NOFREE;
					nofree_seen++;
				end
			end
			FN_WRITE: begin
				if (s < SLOTS && m_refs[s] != 0) begin
					m_dirty[s] = 1;
					r.dreq = DR_WRITE;
				end else r.status = ST_NOTHELD;
			end
			FN_RELEASE: begin
				if (s < SLOTS && m_refs[s] != 0) begin
					m_refs[s]--;
					if (m_refs[s] == 0) begin
						p = 0;
						while (m_order[p] != s) p++;
						for (; p > 0; p--) m_order[p] = m_order[p-1];
						m_order[0] = s;
					end
				end else r.status = ST_NOTHELD;
			end
			default: begin
				if (s < SLOTS) begin
					m_valid[s] = 1;
					m_dirty[s] = 0;
				end else r.status = ST_NOTHELD;
			end
		endcase
		return r;
	endfunction

	assign pending = expected_results.size();

	// Predict on request transfers, compare on response transfers
	always @(posedge clk or negedge arst_n) begin
		cache_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				m_dev[i] = '0; m_blk[i] = '0; m_refs[i] = '0;
				m_valid[i] = 0; m_dirty[i] = 0;
				m_order[i] = SLOTS - 1 - i;
			end
			expected_results.delete();
			errors = 0; gets_hit = 0; gets_miss = 0; nofree_seen = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result slot=%0d hit=%0d req=%0d st=%0d",
						$time, rsp.slot_out, rsp.hit, rsp.disk_request, rsp.status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.slot_out !== want.slot_out || rsp.hit !== want.hit ||
							rsp.disk_request !== want.dreq || rsp.status !== want.status) begin
						$display("%0t: mismatch expected slot=%0d hit=%0d req=%0d st=%0d",
							$time, want.slot_out, want.hit, want.dreq, want.status);
						$display("%0t:          actual slot=%0d hit=%0d req=%0d st=%0d",
							$time, rsp.slot_out, rsp.hit, rsp.disk_request, rsp.status);
						errors++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(cache_apply(req.func, req.device,
					req.block_number, req.slot));
		end
	end
endmodule

[tb/sv/block_buffer_cache_lru_test.sv]
// Top of the block buffer cache testbench: clock, reset, request stimulus and
// response back-pressure. Uses bbc_pkg, both interfaces and the checker.
module block_buffer_cache_lru_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bbc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending, gets_hit, gets_miss, nofree_seen;
	int   sent = 0;
	int   rsp_wait = 0;
	bit   stim_done = 0;
	logic [31:0] pool_blk [8];

	bbc_req_if req ();
	bbc_rsp_if rsp ();

	block_buffer_cache_lru DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	block_buffer_cache_lru_check checker_i (.clk(clk), .arst_n(arst_n), .req(req),
		.rsp(rsp), .errors(errors), .pending(pending), .gets_hit(gets_hit),
		.gets_miss(gets_miss), .nofree_seen(nofree_seen));

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		req.valid = 0; req.func = '0; req.device = '0; req.block_number = '0;
		req.slot = '0; rsp.ready = 0;
	end

	// Drive one request and hold it until its transfer
	task automatic send_op(func_t fn, logic [7:0] dev, logic [31:0] blk, logic [4:0] s);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1; req.func <= fn; req.device <= dev;
		req.block_number <= blk; req.slot <= s;
		do @(posedge clk); while (!req.ready);
		sent++;
	endtask

	// Receiver: random back-pressure before taking each result
	always @(posedge clk) begin
		if (!arst_n || (rsp.valid && rsp.ready)) begin
			rsp_wait = $urandom_range(0, 8);
			rsp.ready <= (rsp_wait == 0);
		end else if (rsp.valid && !rsp.ready) begin
			if (rsp_wait <= 1) rsp.ready <= 1;
			rsp_wait = rsp_wait - 1;
		end
	end

	initial begin
		int k, r;
		logic [4:0] s;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 8; i++) pool_blk[i] = $urandom;
		pool_blk[0] = 0; pool_blk[1] = 32'hFFFF_FFFF;
		// Directed: hit on invalid slot after reset, field extremes, unheld slots
		send_op(FN_GET, 8'd0, 32'd0, 5'd0);
		send_op(FN_COMPLETE, 8'd0, 32'd0, 5'd31);
		send_op(FN_GET, 8'd0, 32'd0, 5'd0);
		send_op(FN_WRITE, 8'd0, 32'd0, 5'd31);
		send_op(FN_WRITE, 8'd0, 32'd0, 5'd3);
		send_op(FN_RELEASE, 8'd0, 32'd0, 5'd3);
		send_op(FN_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
		send_op(FN_RELEASE, 8'd0, 32'd0, 5'd31);
		send_op(FN_RELEASE, 8'd0, 32'd0, 5'd31);
		send_op(FN_RELEASE, 8'd0, 32'd0, 5'd0);
		send_op(FN_COMPLETE, 8'd0, 32'd0, 5'd0);
		// Exhaust the cache: no free clean buffer
		for (int i = 0; i < 33; i++) send_op(FN_GET, 8'hA5, 32'(i + 100), 5'd0);
		// Random: small working set so hits, saturation and exhaustion all occur
		while (sent < 590) begin
			r = $urandom_range(0, 9);
			k = $urandom_range(0, 7);
			s = $urandom_range(0, 31);
			if (r < 4) send_op(FN_GET, $urandom_range(0, 1) ? 8'(k) : 8'($urandom),
				$urandom_range(0, 4) ? pool_blk[$urandom_range(0, 7)] : $urandom, s);
			else if (r < 7) send_op(FN_RELEASE, $urandom, $urandom, s);
			else if (r < 8) send_op(FN_WRITE, $urandom, $urandom, s);
			else send_op(FN_COMPLETE, $urandom, $urandom, s);
		end
		// Saturate one slot's reference count
		for (int i = 0; i < 260; i++) send_op(FN_GET, 8'h5A, 32'h1234_5678, 5'd0);
		req.valid <= 0;
		stim_done = 1;
	end

	// Verdict once all results are in
	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Sent %0d operations: %0d get hits, %0d misses, %0d with no free buffer.",
			sent, gets_hit, gets_miss, nofree_seen);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
